### hdl/slattice_pkg.sv
// Shared types, register codes and control program of the square lattice edge generator.
package slattice_pkg;

    localparam int SIZE_REGS  = 4;
    localparam int SIZE_BITS  = 16;
    localparam int OUT_BITS   = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int PC_BITS    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_DIMS      = 4'd0,
        REG_SIZE_DIM0     = 4'd1,
        REG_SIZE_DIM1     = 4'd2,
        REG_SIZE_DIM2     = 4'd3,
        REG_SIZE_DIM3     = 4'd4,
        REG_PERIODIC_MASK = 4'd5,
        REG_DIRECTED_MODE = 4'd6,
        REG_MUTUAL_MODE   = 4'd7
    } reg_index_t;

    typedef enum logic [3:0] {
        OP_FETCH,
        OP_TEST,
        OP_PROD,
        OP_FWD,
        OP_BWD,
        OP_FLUSH,
        OP_ADVANCE,
        OP_CLEAR,
        OP_STRIDE_TEST,
        OP_STRIDE_MUL,
        OP_STRIDE_DONE
    } op_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_RESTART,
        JMP_DIMS_DONE,
        JMP_STRIDES_DONE
    } jump_t;

    typedef logic [PC_BITS-1:0] pc_t;

    typedef struct packed {
        op_t   op;
        jump_t jump;
        pc_t   target;
    } ucode_t;

    localparam pc_t PC_FETCH       = 4'd0;
    localparam pc_t PC_TEST        = 4'd1;
    localparam pc_t PC_PROD        = 4'd2;
    localparam pc_t PC_FWD         = 4'd3;
    localparam pc_t PC_BWD         = 4'd4;
    localparam pc_t PC_FLUSH       = 4'd5;
    localparam pc_t PC_ADVANCE     = 4'd6;
    localparam pc_t PC_CLEAR       = 4'd7;
    localparam pc_t PC_STRIDE_TEST = 4'd8;
    localparam pc_t PC_STRIDE_MUL  = 4'd9;
    localparam pc_t PC_STRIDE_DONE = 4'd10;

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        case (pc)
            PC_FETCH:       w = '{OP_FETCH,       JMP_RESTART,      PC_CLEAR};
            PC_TEST:        w = '{OP_TEST,        JMP_DIMS_DONE,    PC_FLUSH};
            PC_PROD:        w = '{OP_PROD,        JMP_NEXT,         PC_FETCH};
            PC_FWD:         w = '{OP_FWD,         JMP_NEXT,         PC_FETCH};
            PC_BWD:         w = '{OP_BWD,         JMP_ALWAYS,       PC_TEST};
            PC_FLUSH:       w = '{OP_FLUSH,       JMP_NEXT,         PC_FETCH};
            PC_ADVANCE:     w = '{OP_ADVANCE,     JMP_ALWAYS,       PC_FETCH};
            PC_CLEAR:       w = '{OP_CLEAR,       JMP_NEXT,         PC_FETCH};
            PC_STRIDE_TEST: w = '{OP_STRIDE_TEST, JMP_STRIDES_DONE, PC_STRIDE_DONE};
            PC_STRIDE_MUL:  w = '{OP_STRIDE_MUL,  JMP_ALWAYS,       PC_STRIDE_TEST};
            PC_STRIDE_DONE: w = '{OP_STRIDE_DONE, JMP_ALWAYS,       PC_TEST};
            default:        w = '{OP_FETCH,       JMP_RESTART,      PC_CLEAR};
        endcase
        return w;
    endfunction

endpackage

### hdl/square_lattice_edge_generator.sv
// Square lattice edge generator: microcoded sequencer over a shared stride multiplier.
// A tick is accepted only in the fetch step, after the previous tick's last item has been loaded
// into the output register; a restart tick first recomputes the strides. The sequencer runs one
// step per cycle, except while it waits for a tick or is held by a stalled output.
// Reset: synchronous active-low aresetn; coordinates and index clear, strides go to one,
// registers take their listed reset values.
module square_lattice_edge_generator #(
    parameter int MAX_DIMS    = 4,
    parameter int VERTEX_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // bit 0: restart
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    // bits 31:0 from_vertex, 63:32 to_vertex
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [2*slattice_pkg::OUT_BITS-1:0] m_tdata,
    output logic                                m_tlast,
    // bit 0: edge_valid, bit 1: last_vertex
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [slattice_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slattice_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DW = $clog2(MAX_DIMS + 1);
    localparam int IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int VB = VERTEX_BITS;
    localparam int SB = slattice_pkg::SIZE_BITS;
    localparam int OB = slattice_pkg::OUT_BITS;
    localparam logic [3:0]  MAX_DIMS_4 = 4'(MAX_DIMS);
    localparam logic [DW-1:0] MAX_DIMS_D = DW'(MAX_DIMS);

    // configuration
    logic [2:0]    num_dims_reg;
    logic [SB-1:0] size_reg [slattice_pkg::SIZE_REGS];
    logic [3:0]    periodic_mask_reg;
    logic          directed_reg;
    logic          mutual_reg;

    // sequencer and lattice state
    slattice_pkg::pc_t pc_reg, pc_next;
    logic [DW-1:0] d_reg, d_next;
    logic [SB-1:0] coord_reg [MAX_DIMS];
    logic [SB-1:0] coord_next [MAX_DIMS];
    logic [VB-1:0] vi_reg, vi_next;
    logic [VB-1:0] stride_reg [MAX_DIMS];
    logic [VB-1:0] stride_next [MAX_DIMS];
    logic [VB-1:0] prod_reg, prod_next;

    // pending result and output register
    logic          pend_valid_reg, pend_valid_next;
    logic [VB-1:0] pend_to_reg, pend_to_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [OB-1:0] m_from_reg, m_from_next;
    logic [OB-1:0] m_to_reg, m_to_next;
    logic          m_last_reg, m_last_next;
    logic          m_edge_reg, m_edge_next;
    logic          m_lastv_reg, m_lastv_next;

    slattice_pkg::ucode_t uw;

    logic [SB-1:0] size_arr [MAX_DIMS];
    logic [SB-1:0] top_arr [MAX_DIMS];
    logic          per_arr [MAX_DIMS];
    logic [3:0]    nd4;
    logic [IW-1:0] di, pi;
    logic [SB-1:0] cur_sz, cur_top, cur_c;
    logic          cur_per;
    logic [VB-1:0] cur_stride;
    logic [VB-1:0] mul_a;
    logic [SB-1:0] mul_b;
    logic [VB+SB-1:0] mul_full;
    logic [VB-1:0] fwd_to, bwd_to, cand_to;
    logic          fwd_ok, bwd_ok, cand_ok;
    logic          last_now;
    logic          out_busy;
    logic          stall;
    logic          take;

    always_comb begin
        for (int k = 0; k < MAX_DIMS; k++) begin
            if (k < slattice_pkg::SIZE_REGS) begin
                size_arr[k] = (size_reg[k % slattice_pkg::SIZE_REGS] == '0) ? SB'(1)
                            : size_reg[k % slattice_pkg::SIZE_REGS];
                per_arr[k]  = periodic_mask_reg[k % slattice_pkg::SIZE_REGS];
            end else begin
                size_arr[k] = SB'(1);
                per_arr[k]  = 1'b0;
            end
            top_arr[k] = size_arr[k] - SB'(1);
        end
    end

    assign nd4 = ({1'b0, num_dims_reg} > MAX_DIMS_4) ? MAX_DIMS_4 : {1'b0, num_dims_reg};
    assign di  = d_reg[IW-1:0];
    assign pi  = IW'(d_reg - DW'(1));

    assign cur_sz     = size_arr[di];
    assign cur_top    = top_arr[di];
    assign cur_c      = coord_reg[di];
    assign cur_per    = per_arr[di];
    assign cur_stride = stride_reg[di];

    assign uw = slattice_pkg::ucode_rom(pc_reg);

    // shared multiplier: stride recurrence or wrap offset top*stride
    assign mul_a    = (uw.op == slattice_pkg::OP_STRIDE_MUL) ? stride_reg[pi] : cur_stride;
    assign mul_b    = (uw.op == slattice_pkg::OP_STRIDE_MUL) ? size_arr[pi] : cur_top;
    assign mul_full = (VB+SB)'(mul_a) * (VB+SB)'(mul_b);

    assign fwd_to = (cur_c != cur_top) ? (vi_reg + cur_stride) : (vi_reg - prod_reg);
    assign fwd_ok = (cur_per || (cur_c != cur_top)) && (fwd_to != vi_reg)
                 && ((cur_sz != SB'(2)) || (cur_c != SB'(1)) || directed_reg);
    assign bwd_to = (cur_c != '0) ? (vi_reg - cur_stride) : (vi_reg + prod_reg);
    assign bwd_ok = mutual_reg && directed_reg && (cur_per || (cur_c != '0))
                 && (bwd_to != vi_reg) && ((cur_sz != SB'(2)) || !cur_per);

    assign cand_to = (uw.op == slattice_pkg::OP_FWD) ? fwd_to : bwd_to;
    assign cand_ok = ((uw.op == slattice_pkg::OP_FWD) && fwd_ok)
                  || ((uw.op == slattice_pkg::OP_BWD) && bwd_ok);

    always_comb begin
        last_now = 1'b1;
        for (int k = 0; k < MAX_DIMS; k++) begin
            if ((4'(k) < nd4) && (coord_reg[k] != top_arr[k])) begin
                last_now = 1'b0;
            end
        end
    end

    assign out_busy = m_tvalid_reg && !m_tready;

    always_comb begin
        case (uw.op)
            slattice_pkg::OP_FETCH: stall = !s_tvalid;
            slattice_pkg::OP_FWD,
            slattice_pkg::OP_BWD:   stall = cand_ok && pend_valid_reg && out_busy;
            slattice_pkg::OP_FLUSH: stall = out_busy;
            default:                stall = 1'b0;
        endcase
    end

    always_comb begin
        case (uw.jump)
            slattice_pkg::JMP_ALWAYS:       take = 1'b1;
            slattice_pkg::JMP_RESTART:      take = s_tdata[0];
            slattice_pkg::JMP_DIMS_DONE:    take = (4'(d_reg) == nd4);
            slattice_pkg::JMP_STRIDES_DONE: take = (d_reg == MAX_DIMS_D);
            default:                        take = 1'b0;
        endcase
    end

    always_comb begin
        logic carry;
        pc_next         = pc_reg;
        d_next          = d_reg;
        coord_next      = coord_reg;
        vi_next         = vi_reg;
        stride_next     = stride_reg;
        prod_next       = prod_reg;
        pend_valid_next = pend_valid_reg;
        pend_to_next    = pend_to_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_from_next     = m_from_reg;
        m_to_next       = m_to_reg;
        m_last_next     = m_last_reg;
        m_edge_next     = m_edge_reg;
        m_lastv_next    = m_lastv_reg;
        carry           = 1'b1;

        if (!stall) begin
            pc_next = take ? uw.target : slattice_pkg::pc_t'(pc_reg + 1'b1);
            case (uw.op)
                slattice_pkg::OP_FETCH: begin
                    d_next = '0;
                end
                slattice_pkg::OP_PROD: begin
                    prod_next = mul_full[VB-1:0];
                end
                slattice_pkg::OP_FWD,
                slattice_pkg::OP_BWD: begin
                    if (cand_ok) begin
                        if (pend_valid_reg) begin
                            m_tvalid_next = 1'b1;
                            m_from_next   = OB'(vi_reg);
                            m_to_next     = OB'(pend_to_reg);
                            m_last_next   = 1'b0;
                            m_edge_next   = 1'b1;
                            m_lastv_next  = last_now;
                        end
                        pend_valid_next = 1'b1;
                        pend_to_next    = cand_to;
                    end
                    if (uw.op == slattice_pkg::OP_BWD) begin
                        d_next = d_reg + DW'(1);
                    end
                end
                slattice_pkg::OP_FLUSH: begin
                    m_tvalid_next   = 1'b1;
                    m_from_next     = OB'(vi_reg);
                    m_to_next       = pend_valid_reg ? OB'(pend_to_reg) : '0;
                    m_last_next     = 1'b1;
                    m_edge_next     = pend_valid_reg;
                    m_lastv_next    = last_now;
                    pend_valid_next = 1'b0;
                end
                slattice_pkg::OP_ADVANCE: begin
                    for (int k = 0; k < MAX_DIMS; k++) begin
                        if ((4'(k) < nd4) && carry) begin
                            if (coord_reg[k] != top_arr[k]) begin
                                coord_next[k] = coord_reg[k] + SB'(1);
                                carry = 1'b0;
                            end else begin
                                coord_next[k] = '0;
                            end
                        end
                    end
                    vi_next = carry ? '0 : (vi_reg + VB'(1));
                end
                slattice_pkg::OP_CLEAR: begin
                    for (int k = 0; k < MAX_DIMS; k++) begin
                        coord_next[k] = '0;
                    end
                    vi_next       = '0;
                    stride_next[0] = VB'(1);
                    d_next        = DW'(1);
                end
                slattice_pkg::OP_STRIDE_MUL: begin
                    stride_next[di] = mul_full[VB-1:0];
                    d_next          = d_reg + DW'(1);
                end
                slattice_pkg::OP_STRIDE_DONE: begin
                    d_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_dims_reg      <= 3'd1;
            for (int k = 0; k < slattice_pkg::SIZE_REGS; k++) begin
                size_reg[k] <= SB'(1);
            end
            periodic_mask_reg <= '0;
            directed_reg      <= 1'b0;
            mutual_reg        <= 1'b0;
            pc_reg            <= slattice_pkg::PC_FETCH;
            d_reg             <= '0;
            for (int k = 0; k < MAX_DIMS; k++) begin
                coord_reg[k]  <= '0;
                stride_reg[k] <= VB'(1);
            end
            vi_reg            <= '0;
            pend_valid_reg    <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (slattice_pkg::reg_index_t'(cfg_index))
                    slattice_pkg::REG_NUM_DIMS:      num_dims_reg      <= cfg_data[2:0];
                    slattice_pkg::REG_SIZE_DIM0:     size_reg[0]       <= cfg_data;
                    slattice_pkg::REG_SIZE_DIM1:     size_reg[1]       <= cfg_data;
                    slattice_pkg::REG_SIZE_DIM2:     size_reg[2]       <= cfg_data;
                    slattice_pkg::REG_SIZE_DIM3:     size_reg[3]       <= cfg_data;
                    slattice_pkg::REG_PERIODIC_MASK: periodic_mask_reg <= cfg_data[3:0];
                    slattice_pkg::REG_DIRECTED_MODE: directed_reg      <= cfg_data[0];
                    slattice_pkg::REG_MUTUAL_MODE:   mutual_reg        <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
            pc_reg         <= pc_next;
            d_reg          <= d_next;
            coord_reg      <= coord_next;
            stride_reg     <= stride_next;
            vi_reg         <= vi_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        prod_reg    <= prod_next;
        pend_to_reg <= pend_to_next;
        m_from_reg  <= m_from_next;
        m_to_reg    <= m_to_next;
        m_last_reg  <= m_last_next;
        m_edge_reg  <= m_edge_next;
        m_lastv_reg <= m_lastv_next;
    end

    assign s_tready  = (uw.op == slattice_pkg::OP_FETCH);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {m_to_reg, m_from_reg};
    assign m_tlast   = m_last_reg;
    assign m_tuser   = {m_lastv_reg, m_edge_reg};

endmodule
